FILE: src/msenc_pkg.sv
// Shared types, constants and helpers for the magnetic stripe F2F track encoder.
// No dependencies; the top level, front and back files in src refer to it by scoped names.
`default_nettype none

package msenc_pkg;

  // Widths fixed by the channel fields and registers
  localparam int CHAR_W     = 7;
  localparam int BITS_CFG_W = 3;
  localparam int ZERO_W     = 5;
  localparam int CFG_IDX_W  = 2;

  // Encoding limits
  localparam int MAX_DATA_BITS = 6;
  localparam int MIN_DATA_BITS = 4;
  localparam int MAX_RESULTS   = 64;
  localparam int ZERO_LIMIT    = 25;
  localparam int QUEUE_DEPTH   = 2;

  // Register reset values
  localparam logic [CHAR_W-1:0]     RST_CHAR_OFFSET    = CHAR_W'(32);
  localparam logic [BITS_CFG_W-1:0] RST_DATA_BITS      = BITS_CFG_W'(6);
  localparam logic [ZERO_W-1:0]     RST_LEADING_ZEROS  = ZERO_W'(25);
  localparam logic [ZERO_W-1:0]     RST_TRAILING_ZEROS = ZERO_W'(25);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAR_OFFSET    = 2'd0,
    CFG_DATA_BITS      = 2'd1,
    CFG_LEADING_ZEROS  = 2'd2,
    CFG_TRAILING_ZEROS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              end_of_track;
  } in_t;

  typedef struct packed {
    logic cell_bit;
    logic first_half_level;
    logic second_half_level;
    logic last_cell;
  } out_t;

  typedef struct packed {
    logic [CHAR_W-1:0]     char_offset;
    logic [BITS_CFG_W-1:0] data_bits;
    logic [ZERO_W-1:0]     leading_zeros;
    logic [ZERO_W-1:0]     trailing_zeros;
  } cfg_t;

  // Width of one queued command: start, lead, char word, bit count, last, lrc word, trail
  function automatic int cmd_width(input int mdb);
    return 2 * ZERO_W + 2 * (mdb + 1) + $clog2(mdb + 1) + 2;
  endfunction

  // Saturate a zero-cell count at the cap
  function automatic logic [ZERO_W-1:0] zero_clamp(input logic [ZERO_W-1:0] z,
                                                   input logic [ZERO_W-1:0] cap);
    return (z > cap) ? cap : z;
  endfunction

endpackage

`default_nettype wire

FILE: src/magstripe_track_f2f_encoder.sv
// Top level of the magnetic stripe F2F track encoder: configuration registers,
// front classifier, command queue and back cell sequencer. Depends on msenc_pkg.
//
// Each accepted character yields data_bits + 1 cells (data LSB first, then odd
// parity), one cell per clock from the back sequencer while not stalled, so
// a character takes 5 to MAX_DATA_BITS + 1 cells (7 at reset settings). The
// first character of a track adds leading_zeros cells; the end_of_track character
// adds data_bits + 1 cells for the LRC and trailing_zeros cells. Characters are
// queued two deep, so the input keeps taking beats while cells drain; a restart
// from empty loads the command in S_IDLE first. Zero counts saturate at 25 (less
// for MAX_DATA_BITS over 6). Configuration writes are always taken (cfg_ready is
// tied high) and should be made only while no track is in progress.
`default_nettype none

module magstripe_track_f2f_encoder #(
  parameter int MAX_DATA_BITS = msenc_pkg::MAX_DATA_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [msenc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [msenc_pkg::CHAR_W-1:0]        cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire msenc_pkg::in_t                      in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output msenc_pkg::out_t                          out_data
);

  localparam int CMD_W = msenc_pkg::cmd_width(MAX_DATA_BITS);

  msenc_pkg::cfg_t cfg_r, cfg_nxt;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_not_empty;
  logic [CMD_W-1:0] q_wr_data;
  logic [CMD_W-1:0] q_rd_data;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (msenc_pkg::cfg_idx_t'(cfg_index))
        msenc_pkg::CFG_CHAR_OFFSET:    cfg_nxt.char_offset    = cfg_data;
        msenc_pkg::CFG_DATA_BITS:      cfg_nxt.data_bits      =
                                         cfg_data[msenc_pkg::BITS_CFG_W-1:0];
        msenc_pkg::CFG_LEADING_ZEROS:  cfg_nxt.leading_zeros  =
                                         cfg_data[msenc_pkg::ZERO_W-1:0];
        msenc_pkg::CFG_TRAILING_ZEROS: cfg_nxt.trailing_zeros =
                                         cfg_data[msenc_pkg::ZERO_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.char_offset    <= msenc_pkg::RST_CHAR_OFFSET;
      cfg_r.data_bits      <= msenc_pkg::RST_DATA_BITS;
      cfg_r.leading_zeros  <= msenc_pkg::RST_LEADING_ZEROS;
      cfg_r.trailing_zeros <= msenc_pkg::RST_TRAILING_ZEROS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  msenc_front #(
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .CMD_W         (CMD_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  msenc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (msenc_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (q_wr_data),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  msenc_back #(
    .MAX_DATA_BITS (MAX_DATA_BITS),
    .CMD_W         (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: src/msenc_fifo.sv
// Short command queue between the front classifier and the back cell sequencer.
// Generic width and depth; uses no package items.
`default_nettype none

module msenc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

FILE: src/msenc_front.sv
// Front part: accepts track characters, applies offset, mask, parity and LRC,
// and pushes one command per character. Depends on msenc_pkg.
`default_nettype none

module msenc_front #(
  parameter int MAX_DATA_BITS = msenc_pkg::MAX_DATA_BITS,
  parameter int CMD_W         = msenc_pkg::cmd_width(msenc_pkg::MAX_DATA_BITS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire msenc_pkg::cfg_t   cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire msenc_pkg::in_t    in_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output logic       [CMD_W-1:0] q_data
);

  localparam int BITS_W   = $clog2(MAX_DATA_BITS + 1);
  localparam int WORD_W   = MAX_DATA_BITS + 1;
  localparam int ZW       = msenc_pkg::ZERO_W;
  localparam int DIFF_W   = (MAX_DATA_BITS > msenc_pkg::CHAR_W) ? MAX_DATA_BITS
                                                                : msenc_pkg::CHAR_W;
  localparam int ZERO_FIT = (msenc_pkg::MAX_RESULTS - 2 * (MAX_DATA_BITS + 1)) / 2;
  localparam int ZERO_CAP = (ZERO_FIT < msenc_pkg::ZERO_LIMIT) ? ZERO_FIT
                                                               : msenc_pkg::ZERO_LIMIT;

  typedef struct packed {
    logic              start;
    logic [ZW-1:0]     lead;
    logic [WORD_W-1:0] chr;
    logic [BITS_W-1:0] nbits;
    logic              last;
    logic [WORD_W-1:0] lrc;
    logic [ZW-1:0]     trail;
  } cmd_t;

  logic                         frame_open_r, frame_open_nxt;
  logic [MAX_DATA_BITS-1:0]     lrc_r, lrc_nxt;
  logic                         accept;
  logic [BITS_W-1:0]            cfg_bits;
  logic [BITS_W-1:0]            eff_bits;
  logic [MAX_DATA_BITS-1:0]     mask;
  logic [msenc_pkg::CHAR_W-1:0] diff;
  logic [DIFF_W-1:0]            diff_wide;
  logic [MAX_DATA_BITS-1:0]     value;
  logic [MAX_DATA_BITS-1:0]     lrc_val;
  cmd_t                         cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // Clamp the bit count into the supported range
  assign cfg_bits = BITS_W'(cfg.data_bits);
  always_comb begin
    if (cfg_bits < BITS_W'(msenc_pkg::MIN_DATA_BITS)) begin
      eff_bits = BITS_W'(msenc_pkg::MIN_DATA_BITS);
    end else if (cfg_bits > BITS_W'(MAX_DATA_BITS)) begin
      eff_bits = BITS_W'(MAX_DATA_BITS);
    end else begin
      eff_bits = cfg_bits;
    end
  end

  assign mask = {MAX_DATA_BITS{1'b1}} >> (BITS_W'(MAX_DATA_BITS) - eff_bits);

  // Offset subtraction wraps modulo 128, then keep the low data bits
  assign diff      = in_data.character - cfg.char_offset;
  assign diff_wide = DIFF_W'(diff);
  assign value     = diff_wide[MAX_DATA_BITS-1:0] & mask;

  // Fold into the running LRC, restarting at a track start
  assign lrc_nxt = (frame_open_r ? lrc_r : '0) ^ value;
  assign lrc_val = lrc_nxt & mask;

  // Build the command: parity sits just above the data bits
  always_comb begin
    cmd.start = !frame_open_r;
    cmd.lead  = frame_open_r ? '0
                : msenc_pkg::zero_clamp(cfg.leading_zeros, ZW'(ZERO_CAP));
    cmd.chr   = WORD_W'(value) | (WORD_W'(~^value) << eff_bits);
    cmd.nbits = eff_bits;
    cmd.last  = in_data.end_of_track;
    cmd.lrc   = WORD_W'(lrc_val) | (WORD_W'(~^lrc_val) << eff_bits);
    cmd.trail = msenc_pkg::zero_clamp(cfg.trailing_zeros, ZW'(ZERO_CAP));
  end

  assign q_data         = cmd;
  assign frame_open_nxt = !in_data.end_of_track;

  // Track framing state moves on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      lrc_r        <= '0;
    end else if (accept) begin
      frame_open_r <= frame_open_nxt;
      lrc_r        <= lrc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/msenc_back.sv
// Back part: pops commands and, while the output is not stalled, emits one F2F
// cell per cycle into an output register. Depends on msenc_pkg.
`default_nettype none

module msenc_back #(
  parameter int MAX_DATA_BITS = msenc_pkg::MAX_DATA_BITS,
  parameter int CMD_W         = msenc_pkg::cmd_width(msenc_pkg::MAX_DATA_BITS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire logic  [CMD_W-1:0] q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output msenc_pkg::out_t        out_data
);

  localparam int BITS_W = $clog2(MAX_DATA_BITS + 1);
  localparam int WORD_W = MAX_DATA_BITS + 1;
  localparam int ZW     = msenc_pkg::ZERO_W;
  localparam int CNT_W  = (ZW > BITS_W) ? ZW : BITS_W;

  typedef struct packed {
    logic              start;
    logic [ZW-1:0]     lead;
    logic [WORD_W-1:0] chr;
    logic [BITS_W-1:0] nbits;
    logic              last;
    logic [WORD_W-1:0] lrc;
    logic [ZW-1:0]     trail;
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LEAD  = 5'b00010,
    S_CHAR  = 5'b00100,
    S_LRC   = 5'b01000,
    S_TRAIL = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] shift_r, shift_nxt;
  logic [WORD_W-1:0] lrc_r, lrc_nxt;
  logic [ZW-1:0]     trail_r, trail_nxt;
  logic              last_r, last_nxt;
  logic [BITS_W-1:0] nbits_r, nbits_nxt;
  logic              pol_r, pol_nxt;
  logic              out_valid_r, out_valid_nxt;
  msenc_pkg::out_t   out_data_r, out_data_nxt;

  cmd_t cmd;
  logic adv;
  logic emit;
  logic done;
  logic load;
  logic cbit;
  logic first_lvl;
  logic second_lvl;

  assign cmd       = q_data;
  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Bit of the current cell: shifted data in character and LRC, zero elsewhere
  assign cbit = ((state_r == S_CHAR) || (state_r == S_LRC)) ? shift_r[0] : 1'b0;

  // F2F levels: flip at cell start, flip again at mid-cell for a one
  assign first_lvl  = ~pol_r;
  assign second_lvl = cbit ? pol_r : ~pol_r;

  // Cell sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    lrc_nxt       = lrc_r;
    trail_nxt     = trail_r;
    last_nxt      = last_r;
    nbits_nxt     = nbits_r;
    pol_nxt       = pol_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    emit          = 1'b0;
    done          = 1'b0;
    load          = 1'b0;
    q_pop         = 1'b0;

    if (adv) begin
      case (state_r)
        S_IDLE: begin
          load = q_valid;
        end
        S_LEAD: begin
          emit = 1'b1;
          if (cnt_r == '0) begin
            state_nxt = S_CHAR;
            cnt_nxt   = CNT_W'(nbits_r);
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        S_CHAR: begin
          emit      = 1'b1;
          shift_nxt = shift_r >> 1;
          if (cnt_r == '0) begin
            if (last_r) begin
              state_nxt = S_LRC;
              shift_nxt = lrc_r;
              cnt_nxt   = CNT_W'(nbits_r);
            end else begin
              done = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        S_LRC: begin
          emit      = 1'b1;
          shift_nxt = shift_r >> 1;
          if (cnt_r == '0) begin
            if (trail_r != '0) begin
              state_nxt = S_TRAIL;
              cnt_nxt   = CNT_W'(trail_r - 1'b1);
            end else begin
              done = 1'b1;
            end
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        S_TRAIL: begin
          emit = 1'b1;
          if (cnt_r == '0) begin
            done = 1'b1;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase

      // Register the emitted cell
      out_valid_nxt = emit;
      if (emit) begin
        pol_nxt                        = second_lvl;
        out_data_nxt.cell_bit          = cbit;
        out_data_nxt.first_half_level  = first_lvl;
        out_data_nxt.second_half_level = second_lvl;
        out_data_nxt.last_cell         = done;
      end

      // Take the next command straight after the final cell of the current one
      if (done) begin
        load = q_valid;
      end

      if (load) begin
        q_pop     = 1'b1;
        shift_nxt = cmd.chr;
        lrc_nxt   = cmd.lrc;
        trail_nxt = cmd.trail;
        last_nxt  = cmd.last;
        nbits_nxt = cmd.nbits;
        if (cmd.start) begin
          pol_nxt = 1'b0;
        end
        if (cmd.lead != '0) begin
          state_nxt = S_LEAD;
          cnt_nxt   = CNT_W'(cmd.lead - 1'b1);
        end else begin
          state_nxt = S_CHAR;
          cnt_nxt   = CNT_W'(cmd.nbits);
        end
      end else if (done) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pol_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pol_r       <= pol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold command payload and output cell
  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    lrc_r      <= lrc_nxt;
    trail_r    <= trail_nxt;
    last_r     <= last_nxt;
    nbits_r    <= nbits_nxt;
    out_data_r <= out_data_nxt;
  end

  a_pol_follows_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_cell |-> pol_r == out_data_r.second_half_level)
    else $error("coil polarity lost track of the last emitted half cell");

  a_mid_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.last_cell |-> state_r != S_IDLE)
    else $error("sequencer went idle before the final cell of an item");

endmodule

`default_nettype wire
